FILE: rtl/core/ulsr_pkg.sv
// Package for the unordered list with swap-remove.
// Holds the item structs and the mode codes; no dependencies.
package ulsr_pkg;

    localparam logic [1:0] MODE_APPEND     = 2'd0;
    localparam logic [1:0] MODE_REMOVE_ONE = 2'd1;
    localparam logic [1:0] MODE_REMOVE_ALL = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] item_value;
    } ulsr_in_t;

    typedef struct packed {
        logic       accepted;
        logic [6:0] removed_count;
        logic [6:0] entries_held;
    } ulsr_out_t;

endpackage

FILE: rtl/core/unordered_list_swap_remove.sv
// Unordered list of signed 32-bit values with append and swap-remove, held in
// one two-read, one-write synchronous memory of CAPACITY entries. The result of an
// append, an unused mode or a removal from an empty list is registered from the
// finish state, which the item enters when it is accepted. A removal makes one
// comparison per cycle from the lowest position, comparing the entry read through
// one memory port while the last entry arrives on the other; a match overwrites the
// entry with the last one. A remove-one stops at the first match, so it makes match
// position + 1 comparisons, or as many as entries held when nothing matches. A
// remove-all checks the same position again after a match, so every kept entry
// fails once and every removed entry matches once: exactly as many comparisons as
// entries held. Its result is registered from the finish state, entered after the
// last comparison; the block returns to idle, where the next item is taken, as the
// result rises. One item is in work at a time; a new item is taken while the
// previous result still waits in the output register, and a second finished
// result holds the input until the receiver takes the first. Depends on ulsr_pkg.
module unordered_list_swap_remove
    import ulsr_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ulsr_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output ulsr_out_t m_data
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CW-1:0] CAP_W = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_W = CW'(1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    logic [31:0] mem [0:CAPACITY-1];

    state_t      state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] removed_reg, removed_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [31:0] value_reg, value_next;
    logic        all_reg, all_next;
    logic        acc_reg, acc_next;
    logic [31:0] hold_reg, hold_next;
    logic        a_hold_reg, a_hold_next;
    logic        b_hold_reg, b_hold_next;
    logic        m_valid_reg;
    ulsr_out_t   m_data_reg;

    logic [31:0] rd_a_reg, rd_b_reg;
    logic [AW-1:0] raddr_a, raddr_b, waddr;
    logic [31:0] wdata;
    logic        we;

    logic [31:0]   cur_data, last_data;
    logic          match;
    logic [CW-1:0] idx_ext, idx_plus, count_less;
    logic          out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;

    assign cur_data   = a_hold_reg ? hold_reg : rd_a_reg;
    assign last_data  = b_hold_reg ? hold_reg : rd_b_reg;
    assign match      = (cur_data == value_reg);
    assign idx_ext    = CW'(idx_reg);
    assign idx_plus   = idx_ext + ONE_W;
    assign count_less = count_reg - ONE_W;

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        removed_next = removed_reg;
        idx_next     = idx_reg;
        value_next   = value_reg;
        all_next     = all_reg;
        acc_next     = acc_reg;
        hold_next    = hold_reg;
        a_hold_next  = a_hold_reg;
        b_hold_next  = b_hold_reg;
        we           = 1'b0;
        waddr        = count_reg[AW-1:0];
        wdata        = s_data.item_value;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    value_next   = s_data.item_value;
                    all_next     = (s_data.mode == MODE_REMOVE_ALL);
                    removed_next = '0;
                    acc_next     = 1'b0;
                    idx_next     = '0;
                    a_hold_next  = 1'b0;
                    b_hold_next  = 1'b0;
                    state_next   = ST_FIN;
                    if (s_data.mode == MODE_APPEND) begin
                        if (count_reg < CAP_W) begin
                            we         = 1'b1;
                            count_next = count_reg + ONE_W;
                            acc_next   = 1'b1;
                        end
                    end else if (s_data.mode == MODE_REMOVE_ONE ||
                                 s_data.mode == MODE_REMOVE_ALL) begin
                        if (count_reg != '0) begin
                            state_next = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (match) begin
                    we           = 1'b1;
                    waddr        = idx_reg;
                    wdata        = last_data;
                    count_next   = count_less;
                    removed_next = removed_reg + ONE_W;
                    hold_next    = last_data;
                    a_hold_next  = 1'b1;
                    b_hold_next  = (idx_ext == count_less - ONE_W);
                    if (!all_reg || idx_ext >= count_less) begin
                        acc_next   = 1'b1;
                        state_next = ST_FIN;
                    end
                end else begin
                    a_hold_next = 1'b0;
                    b_hold_next = 1'b0;
                    if (idx_plus >= count_reg) begin
                        acc_next   = (removed_reg != '0);
                        state_next = ST_FIN;
                    end else begin
                        idx_next = idx_plus[AW-1:0];
                    end
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign raddr_a = idx_next;
    assign raddr_b = AW'(count_next - ONE_W);

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_a_reg <= mem[raddr_a];
        rd_b_reg <= mem[raddr_b];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (state_reg == ST_FIN && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        removed_reg <= removed_next;
        idx_reg     <= idx_next;
        value_reg   <= value_next;
        all_reg     <= all_next;
        acc_reg     <= acc_next;
        hold_reg    <= hold_next;
        a_hold_reg  <= a_hold_next;
        b_hold_reg  <= b_hold_next;
        if (state_reg == ST_FIN && out_free) begin
            m_data_reg.accepted      <= acc_reg;
            m_data_reg.removed_count <= 7'(removed_reg);
            m_data_reg.entries_held  <= 7'(count_reg);
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_W)
        else $error("entry count above capacity");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> idx_ext < count_reg)
        else $error("scan position beyond entry count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN && we |=> count_reg == $past(count_reg) - ONE_W)
        else $error("removal did not shrink the list");

    assert property (@(posedge aclk) disable iff (!aresetn)
        we |-> state_reg != ST_FIN)
        else $error("memory write while a result is pending");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FIN && out_free |=> m_valid_reg && state_reg == ST_IDLE)
        else $error("result not presented");

endmodule

FILE: tb/testbench.sv
// Testbench for unordered_list_swap_remove: a table of directed items, then random
// phases of appends, swap-removes and unused modes, checked by a local list
// predictor. Depends on ulsr_pkg and the unordered_list_swap_remove RTL.
module testbench;
    import ulsr_pkg::*;

    localparam int         CAPACITY     = 64;
    localparam int         RANDOM_ITEMS = 700;
    localparam int         LIMIT_CYCLES = 1_500_000;
    localparam int         LONG_HOLD    = 400;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] value;
        bit          typed;
        ulsr_out_t   want;
    } table_row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    ulsr_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    ulsr_out_t m_data;

    bit        row_typed;
    ulsr_out_t row_want;
    bit        no_idle;
    bit        hold_off_req;
    int        fail_count;
    int        cycle_count;

    logic [31:0] list_vals [CAPACITY];
    int          list_len;
    ulsr_out_t   result_q [$];
    table_row_t  dir_rows [$];

    unordered_list_swap_remove #(.CAPACITY(CAPACITY)) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic ulsr_out_t list_apply(ulsr_in_t it);
        ulsr_out_t r;
        int        pos;
        int        removed;
        bit        hit;
        r       = '0;
        removed = 0;
        case (it.mode)
            MODE_APPEND: begin
                if (list_len < CAPACITY) begin
                    list_vals[list_len] = it.item_value;
                    list_len++;
                    r.accepted = 1'b1;
                end
            end
            MODE_REMOVE_ONE, MODE_REMOVE_ALL: begin
                do begin
                    hit = 1'b0;
                    for (pos = 0; pos < list_len && !hit; pos++) begin
                        if (list_vals[pos] == it.item_value) begin
                            list_vals[pos] = list_vals[list_len - 1];
                            list_len--;
                            hit = 1'b1;
                        end
                    end
                    if (hit) removed++;
                end while (hit && it.mode == MODE_REMOVE_ALL);
                r.accepted      = (removed != 0);
                r.removed_count = removed[6:0];
            end
            default: ;
        endcase
        r.entries_held = list_len[6:0];
        return r;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    always @(posedge aclk) begin : result_check
        ulsr_out_t want;
        ulsr_out_t got;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                want = list_apply(s_data);
                if (row_typed) want = row_want;
                result_q.push_back(want);
            end
            if (m_valid && m_ready) begin
                got = m_data;
                if (result_q.size() == 0) begin
                    $error("result with none pending: %p", got);
                    fail_count++;
                end else begin
                    want = result_q.pop_front();
                    if (got.accepted !== want.accepted) begin
                        $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
                        fail_count++;
                    end
                    if (got.removed_count !== want.removed_count) begin
                        $error("removed_count: expected %0d, got %0d",
                               want.removed_count, got.removed_count);
                        fail_count++;
                    end
                    if (got.entries_held !== want.entries_held) begin
                        $error("entries_held: expected %0d, got %0d",
                               want.entries_held, got.entries_held);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall = LONG_HOLD;
            end else if (no_idle) begin
                stall = 0;
            end else begin
                stall = idle_len();
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    task automatic offer(input logic [1:0] m, input logic [31:0] v, input bit typed,
                         input ulsr_out_t want);
        int       gap;
        ulsr_in_t it;
        gap = no_idle ? 0 : idle_len();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        it.mode       = m;
        it.item_value = v;
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_data    <= it;
        row_typed <= typed;
        row_want  <= want;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge aclk);
    endtask

    task automatic dir_row(input logic [1:0] m, input logic [31:0] v, input bit typed,
                           input bit a, input int r, input int h);
        table_row_t row;
        row.mode  = m;
        row.value = v;
        row.typed = typed;
        row.want  = '{accepted: a, removed_count: r[6:0], entries_held: h[6:0]};
        dir_rows.push_back(row);
    endtask

    initial begin : stimulus
        logic [31:0] pool [6];
        logic [31:0] v;
        logic [1:0]  m;
        int          sent;
        int          phase;
        int          kind;
        int          len;
        int          p_app;
        int          r;

        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        row_typed    = 1'b0;
        row_want     = '0;
        no_idle      = 1'b0;
        hold_off_req = 1'b0;
        fail_count   = 0;
        cycle_count  = 0;
        list_len     = 0;
        for (int i = 0; i < CAPACITY; i++) list_vals[i] = '0;

        dir_row(MODE_REMOVE_ONE, 32'd5,        1, 0, 0, 0);
        dir_row(MODE_REMOVE_ALL, 32'd5,        1, 0, 0, 0);
        dir_row(MODE_UNUSED,     32'd0,        1, 0, 0, 0);
        dir_row(MODE_APPEND,     32'h7FFFFFFF, 1, 1, 0, 1);
        dir_row(MODE_APPEND,     32'h80000000, 1, 1, 0, 2);
        dir_row(MODE_APPEND,     32'hFFFFFFFF, 1, 1, 0, 3);
        dir_row(MODE_APPEND,     32'd0,        1, 1, 0, 4);
        dir_row(MODE_APPEND,     32'hFFFFFFFF, 1, 1, 0, 5);
        dir_row(MODE_APPEND,     32'h7FFFFFFF, 1, 1, 0, 6);
        dir_row(MODE_REMOVE_ONE, 32'h7FFFFFFF, 1, 1, 1, 5);
        dir_row(MODE_REMOVE_ONE, 32'h7FFFFFFE, 1, 0, 0, 5);
        dir_row(MODE_UNUSED,     32'hFFFFFFFF, 0, 0, 0, 0);
        dir_row(MODE_REMOVE_ALL, 32'hFFFFFFFF, 1, 1, 2, 3);
        dir_row(MODE_REMOVE_ONE, 32'h80000000, 1, 1, 1, 2);
        dir_row(MODE_APPEND,     32'd0,        1, 1, 0, 3);
        dir_row(MODE_APPEND,     32'd7,        1, 1, 0, 4);
        dir_row(MODE_REMOVE_ONE, 32'd7,        1, 1, 1, 3);
        dir_row(MODE_REMOVE_ALL, 32'd0,        1, 1, 2, 1);
        dir_row(MODE_REMOVE_ALL, 32'h7FFFFFFF, 1, 1, 1, 0);
        dir_row(MODE_APPEND,     32'h55555555, 0, 0, 0, 0);
        dir_row(MODE_APPEND,     32'hAAAAAAAA, 0, 0, 0, 0);
        dir_row(MODE_REMOVE_ALL, 32'hAAAAAAAA, 0, 0, 0, 0);
        dir_row(MODE_REMOVE_ONE, 32'h55555555, 1, 1, 1, 0);

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i])
            offer(dir_rows[i].mode, dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);

        // fill to capacity with one value, overflow twice, then clear it in one item
        v = $urandom;
        repeat (CAPACITY + 2) offer(MODE_APPEND, v, 0, '0);
        offer(MODE_REMOVE_ALL, v, 0, '0);
        drain_results();

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            foreach (pool[i]) begin
                case ($urandom_range(0, 3))
                    0: pool[i] = $urandom_range(0, 15);
                    1: begin
                        case ($urandom_range(0, 3))
                            0: pool[i] = 32'h7FFFFFFF;
                            1: pool[i] = 32'h80000000;
                            2: pool[i] = 32'hFFFFFFFF;
                            default: pool[i] = 32'd0;
                        endcase
                    end
                    default: pool[i] = $urandom;
                endcase
            end
            kind = $urandom_range(0, 2);
            p_app = (kind == 0) ? 85 : (kind == 1) ? 20 : 50;
            len = $urandom_range(30, 90);
            no_idle = ($urandom_range(0, 3) == 0);
            if (phase == 3) begin
                no_idle = 1'b0;
                hold_off_req = 1'b1;
            end
            repeat (len) begin
                r = $urandom_range(0, 99);
                if (r < p_app) begin
                    m = MODE_APPEND;
                end else begin
                    r = $urandom_range(0, 19);
                    m = (r < 9) ? MODE_REMOVE_ONE : (r < 18) ? MODE_REMOVE_ALL : MODE_UNUSED;
                end
                v = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, 5)];
                offer(m, v, 0, '0);
                sent++;
            end
            if ($urandom_range(0, 3) == 0) drain_results();
            phase++;
        end
        no_idle = 1'b0;

        drain_results();
        repeat (2 * CAPACITY + 20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
